// ----- sv/tfsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature to fan speed controller package
// Shared types, register indexes, reset values and divider sizing.
// ----------------------------------------------------------------------------
package tfsc_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TDIV,
        S_RULE,
        S_MUL,
        S_RDIV,
        S_APPLY,
        S_DONE
    } tfsc_state_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_SPEED_FLOOR    = 3'd0;
    localparam logic [2:0] REG_SPEED_CEILING  = 3'd1;
    localparam logic [2:0] REG_COOL_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_RAMP_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_HOT_THRESHOLD  = 3'd4;

    // Register values after reset.
    localparam logic [15:0] RST_SPEED_FLOOR    = 16'd2000;
    localparam logic [15:0] RST_SPEED_CEILING  = 16'd6200;
    localparam logic [6:0]  RST_COOL_THRESHOLD = 7'd63;
    localparam logic [6:0]  RST_RAMP_THRESHOLD = 7'd66;
    localparam logic [6:0]  RST_HOT_THRESHOLD  = 7'd86;

    // Divider sizing. The dividend register holds the ramp numerator, which
    // is at most T(127) * 65535 plus the divisor less one, in 30 bits.
    localparam int DVD_W       = 30;
    localparam int DEN_W       = 13;
    localparam int TEMP_NUM_W  = 19;
    localparam int TEMP_STEPS  = TEMP_NUM_W;
    localparam int RAMP_STEPS  = DVD_W;
    localparam int CNT_W       = 5;

    // Millidegree sum of two readings per degree of their average, and the rounding offset for a ceiling.
    localparam logic [DEN_W-1:0]      TEMP_DIVISOR = 13'd2000;
    localparam logic [TEMP_NUM_W-1:0] TEMP_ROUND   = 19'd1999;

    // Triangular number n(n+1)/2 for a 7-bit n; the result fits 13 bits.
    function automatic logic [DEN_W-1:0] tri_num(input logic [6:0] n);
        logic [13:0] n_ext;
        logic [13:0] prod;
        n_ext = {7'd0, n};
        prod  = n_ext * (n_ext + 14'd1);
        return prod[13:1];
    endfunction

endpackage

// ----- sv/temp_to_fan_speed_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature to fan speed controller core
// Averages two sensor readings each poll tick and steps the fan speed
// command along triangular ramps between the cool and hot thresholds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, sensor_a, sensor_b): one item per poll
//   tick, taken when in_valid is high and in_stall is low. in_stall stays
//   high while an item is being worked on.
//   Output channel (out_valid, out_stall, drive_speed, avg_temp): one item
//   per input item, held steady while out_stall is high.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): five
//   registers, always ready; write only while the block is idle.
// Division: one restoring divider, one quotient bit per cycle, does all the
//   division. The average takes 19 steps; a tick on a ramp adds a multiply
//   and a 30-step division. A new item is taken in the cycle after the
//   previous result is handed to the output register.
// Reset: registers return to their defaults, the speed to the floor, and
//   the next item is treated as the first sample.
// Stall: a finished result waits in the sequencer until the output
//   register is free; no item is ever dropped.
// ----------------------------------------------------------------------------
module temp_to_fan_speed_controller_core
    import tfsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [16:0] sensor_a,
    input  logic [16:0] sensor_b,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] drive_speed,
    output logic [7:0]  avg_temp,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Control and state registers.
    tfsc_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              primed_reg, primed_next;
    logic [7:0]        prev_temp_reg, prev_temp_next;
    logic [15:0]       cur_speed_reg, cur_speed_next;
    logic              out_valid_reg, out_valid_next;

    // Configuration registers.
    logic [15:0]       floor_reg, ceiling_reg;
    logic [6:0]        cool_reg, ramp_reg, hot_reg;

    // Datapath registers.
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  steps_reg, steps_next;
    logic              dir_up_reg, dir_up_next;
    logic [7:0]        temp_reg, temp_next;
    logic [15:0]       drive_speed_reg, drive_speed_next;
    logic [7:0]        avg_temp_reg, avg_temp_next;

    // Shared divider step and helpers.
    logic [DEN_W:0]    rem_sh;
    logic              rem_ge;
    logic [DEN_W:0]    rem_diff;
    logic [15:0]       range_w;
    logic [7:0]        t_w;
    logic [7:0]        hot_ext, cool_ext, ramp_ext;
    logic [18:0]       sum_w;
    logic [28:0]       prod_w;
    logic [16:0]       quo_w;
    logic [16:0]       up_cand;
    logic [15:0]       speed_tmp;
    logic              rising, falling;
    logic              accept_in, out_free;

    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign drive_speed = drive_speed_reg;
    assign avg_temp    = avg_temp_reg;

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor when it fits.
    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign rem_diff = rem_sh - {1'b0, den_reg};

    assign range_w  = (ceiling_reg >= floor_reg) ? (ceiling_reg - floor_reg) : 16'd0;
    assign hot_ext  = {1'b0, hot_reg};
    assign cool_ext = {1'b0, cool_reg};
    assign ramp_ext = {1'b0, ramp_reg};
    assign t_w      = dvd_reg[7:0];
    assign sum_w    = {2'b00, sensor_a} + {2'b00, sensor_b} + TEMP_ROUND;
    assign prod_w   = 29'(steps_reg) * 29'(range_w);
    assign quo_w    = dvd_reg[16:0];
    assign up_cand  = {1'b0, floor_reg} + quo_w;

    assign rising  = (t_w > prev_temp_reg) && (t_w > ramp_ext) && (t_w < hot_ext);
    assign falling = (t_w < prev_temp_reg) && (t_w > cool_ext) && (t_w < hot_ext);

    // Band rules applied ahead of the ramps; the cool rule wins.
    always_comb
    begin
        speed_tmp = cur_speed_reg;
        if (t_w >= hot_ext)
        begin
            speed_tmp = ceiling_reg;
        end
        if (t_w <= cool_ext)
        begin
            speed_tmp = floor_reg;
        end
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        primed_next      = primed_reg;
        prev_temp_next   = prev_temp_reg;
        cur_speed_next   = cur_speed_reg;
        out_valid_next   = out_valid_reg && out_stall;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        den_next         = den_reg;
        steps_next       = steps_reg;
        dir_up_next      = dir_up_reg;
        temp_next        = temp_reg;
        drive_speed_next = drive_speed_reg;
        avg_temp_next    = avg_temp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    dvd_next   = {sum_w, {(DVD_W - TEMP_NUM_W){1'b0}}};
                    rem_next   = '0;
                    den_next   = TEMP_DIVISOR;
                    cnt_next   = CNT_W'(TEMP_STEPS);
                    state_next = S_TDIV;
                end
            end

            S_TDIV, S_RDIV:
            begin
                rem_next = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], rem_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = (state_reg == S_TDIV) ? S_RULE : S_APPLY;
                end
            end

            S_RULE:
            begin
                temp_next      = t_w;
                prev_temp_next = t_w;
                if (!primed_reg)
                begin
                    primed_next    = 1'b1;
                    cur_speed_next = floor_reg;
                    state_next     = S_DONE;
                end
                else
                begin
                    cur_speed_next = speed_tmp;
                    dir_up_next    = rising;
                    if (rising)
                    begin
                        steps_next = tri_num(7'(t_w - ramp_ext));
                        den_next   = tri_num(7'(hot_ext - ramp_ext));
                        state_next = S_MUL;
                    end
                    else if (falling)
                    begin
                        steps_next = tri_num(7'(hot_ext - t_w));
                        den_next   = tri_num(7'(hot_ext - cool_ext));
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_MUL:
            begin
                // Numerator for a ceiling division by the ramp span.
                dvd_next   = 30'(prod_w) + 30'(den_reg) - 30'd1;
                rem_next   = '0;
                cnt_next   = CNT_W'(RAMP_STEPS);
                state_next = S_RDIV;
            end

            S_APPLY:
            begin
                if (dir_up_reg)
                begin
                    if (up_cand[16])
                    begin
                        if (cur_speed_reg != 16'hFFFF)
                        begin
                            cur_speed_next = 16'hFFFF;
                        end
                    end
                    else if (up_cand[15:0] > cur_speed_reg)
                    begin
                        cur_speed_next = up_cand[15:0];
                    end
                end
                else
                begin
                    if (quo_w > {1'b0, ceiling_reg})
                    begin
                        cur_speed_next = 16'd0;
                    end
                    else if ((ceiling_reg - quo_w[15:0]) < cur_speed_reg)
                    begin
                        cur_speed_next = ceiling_reg - quo_w[15:0];
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    drive_speed_next = cur_speed_reg;
                    avg_temp_next    = temp_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            primed_reg    <= 1'b0;
            prev_temp_reg <= 8'd0;
            cur_speed_reg <= RST_SPEED_FLOOR;
            out_valid_reg <= 1'b0;
            floor_reg     <= RST_SPEED_FLOOR;
            ceiling_reg   <= RST_SPEED_CEILING;
            cool_reg      <= RST_COOL_THRESHOLD;
            ramp_reg      <= RST_RAMP_THRESHOLD;
            hot_reg       <= RST_HOT_THRESHOLD;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            primed_reg    <= primed_next;
            prev_temp_reg <= prev_temp_next;
            cur_speed_reg <= cur_speed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SPEED_FLOOR:    floor_reg   <= cfg_data;
                    REG_SPEED_CEILING:  ceiling_reg <= cfg_data;
                    REG_COOL_THRESHOLD: cool_reg    <= cfg_data[6:0];
                    REG_RAMP_THRESHOLD: ramp_reg    <= cfg_data[6:0];
                    REG_HOT_THRESHOLD:  hot_reg     <= cfg_data[6:0];
                    default:            ;
                endcase
            end
        end
    end

    // Datapath registers; their contents matter only under the sequencer.
    always_ff @(posedge clk)
    begin
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        den_reg         <= den_next;
        steps_reg       <= steps_next;
        dir_up_reg      <= dir_up_next;
        temp_reg        <= temp_next;
        drive_speed_reg <= drive_speed_next;
        avg_temp_reg    <= avg_temp_next;
    end

    // An accepted item always starts the averaging division.
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == S_TDIV) && (cnt_reg == CNT_W'(TEMP_STEPS)))
        else $error("accepted item did not start the temperature division");

    // The averaged temperature always fits in eight bits.
    a_temp_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RULE) |-> (dvd_reg[DVD_W-1:8] == '0))
        else $error("averaged temperature exceeds eight bits");

    // A ramp division never runs with a zero divisor.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDIV) |-> (den_reg != '0))
        else $error("ramp division started with a zero divisor");

    // The step counter never runs out while dividing.
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_TDIV) || (state_reg == S_RDIV)) |-> (cnt_reg != '0))
        else $error("divider step counter underflow");

    // A result is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result left the sequencer while the output was stalled");

endmodule

// ----- verif/tb_temp_to_fan_speed_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the temperature to fan speed controller core
// Sends pairs of sensor readings through the stall handshake. A scoreboard
// predicts the averaged temperature and the fan speed command for every item
// accepted. The run covers a directed set of corner readings, then random
// temperature walks under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_temp_to_fan_speed_controller_core;
    import tfsc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int MDEG_PER_DEG   = 2000;
    localparam int SENSOR_MAX     = 131071;
    localparam int MAX_DEG        = 133 - 1;
    localparam int REG_SPACE      = 8;
    localparam int PHASES         = 9;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int QUIET_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 200;

    // One fan command as it leaves the block.
    typedef struct packed {
        logic [15:0] speed;
        logic [7:0]  deg;
    } fan_cmd_t;

    // Predicts the fan command for each accepted reading and checks results.
    class fan_cmd_scoreboard;
        logic [15:0] floor_rpm;
        logic [15:0] ceil_rpm;
        logic [6:0]  cool_deg;
        logic [6:0]  ramp_deg;
        logic [6:0]  hot_deg;
        logic [7:0]  last_deg;
        logic [15:0] speed_now;
        bit          primed;
        fan_cmd_t    fan_cmd_q[$];
        int          errors;

        function new();
            floor_rpm = RST_SPEED_FLOOR;
            ceil_rpm  = RST_SPEED_CEILING;
            cool_deg  = RST_COOL_THRESHOLD;
            ramp_deg  = RST_RAMP_THRESHOLD;
            hot_deg   = RST_HOT_THRESHOLD;
            last_deg  = 8'd0;
            speed_now = RST_SPEED_FLOOR;
            primed    = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_SPEED_FLOOR:    floor_rpm = data;
                REG_SPEED_CEILING:  ceil_rpm  = data;
                REG_COOL_THRESHOLD: cool_deg  = data[6:0];
                REG_RAMP_THRESHOLD: ramp_deg  = data[6:0];
                REG_HOT_THRESHOLD:  hot_deg   = data[6:0];
                default: ;
            endcase
        endfunction

        function longint unsigned tri_count(longint unsigned n);
            return n * (n + 1) / 2;
        endfunction

        function longint unsigned div_up(longint unsigned num, longint unsigned den);
            if (den == 0)
                return 0;
            return (num + den - 1) / den;
        endfunction

        function void note_reading(logic [16:0] a, logic [16:0] b);
            longint unsigned t, old, fl, ce, co, ra, ho;
            longint unsigned span, cand, sub, spd;
            fan_cmd_t        cmd;
            t   = div_up(64'(a) + 64'(b), MDEG_PER_DEG) & 64'hFF;
            old = last_deg;
            fl  = floor_rpm;
            ce  = ceil_rpm;
            co  = cool_deg;
            ra  = ramp_deg;
            ho  = hot_deg;
            spd = speed_now;
            if (!primed) begin
                // The first tick records the temperature and sets the speed to the floor.
                primed = 1'b1;
                spd    = fl;
            end
            else begin
                span = (ce >= fl) ? ce - fl : 0;
                if (t >= ho)
                    spd = ce;
                if (t <= co)
                    spd = fl;
                // Rising between the bands: climb the upper ramp.
                if (t > old && t > ra && t < ho) begin
                    cand = fl + div_up(tri_count(t - ra) * span, tri_count(ho - ra));
                    if (cand > 64'hFFFF)
                        cand = 64'hFFFF;
                    if (cand > spd)
                        spd = cand;
                end
                // Falling between the bands: drop along the lower ramp.
                if (t < old && t > co && t < ho) begin
                    sub  = div_up(tri_count(ho - t) * span, tri_count(ho - co));
                    cand = (sub <= ce) ? ce - sub : 0;
                    if (cand < spd)
                        spd = cand;
                end
            end
            speed_now = spd[15:0];
            last_deg  = t[7:0];
            cmd.speed = speed_now;
            cmd.deg   = last_deg;
            fan_cmd_q.push_back(cmd);
        endfunction

        function void check_result(logic [15:0] speed, logic [7:0] deg);
            fan_cmd_t want;
            if (fan_cmd_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, drive_speed %0d avg_temp %0d",
                         $time, speed, deg);
                return;
            end
            want = fan_cmd_q.pop_front();
            if (speed !== want.speed) begin
                errors++;
                $display("%0t: drive_speed expected %0d actual %0d",
                         $time, want.speed, speed);
            end
            if (deg !== want.deg) begin
                errors++;
                $display("%0t: avg_temp expected %0d actual %0d", $time, want.deg, deg);
            end
        endfunction

        function int backlog();
            return fan_cmd_q.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [16:0] sensor_a  = 17'd0;
    logic [16:0] sensor_b  = 17'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] drive_speed;
    logic [7:0]  avg_temp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data  = 16'd0;

    fan_cmd_scoreboard sb;
    int send_pct  = 0;
    int stall_pct = 0;
    int quiet     = 0;

    temp_to_fan_speed_controller_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sensor_a    (sensor_a),
        .sensor_b    (sensor_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive_speed (drive_speed),
        .avg_temp    (avg_temp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver back-pressure.
    always @(negedge clk)
        out_stall <= ($urandom_range(1, 100) <= stall_pct);

    // Result monitor.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(drive_speed, avg_temp);

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Presents one reading, with optional idle cycles first.
    task automatic push_reading(input logic [16:0] a, input logic [16:0] b);
        while ($urandom_range(1, 100) <= send_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sensor_a <= a;
        sensor_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_reading(a, b);
        @(negedge clk);
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.backlog() != 0)
            @(negedge clk);
    endtask

    // One register write; valid is left high for a following write.
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Threshold value with random junk in the unused upper bits.
    function automatic logic [15:0] thr_data(input logic [6:0] deg);
        return {9'($urandom), deg};
    endfunction

    initial begin
        int          phase, n, k;
        int          deg, dir, s, lo, hi, ia, roll;
        logic [16:0] a, b;
        logic [15:0] fl, ce;
        logic [6:0]  co, ra, ho;

        sb  = new();
        deg = 70;
        dir = 1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed readings under the reset settings.
        push_reading(17'd100000, 17'd100000);   // first tick: floor only
        push_reading(17'd100000, 17'd100000);   // hot
        push_reading(17'd0, 17'd0);             // coldest reading
        push_reading(17'h1FFFF, 17'h1FFFF);     // both sensors above range
        push_reading(17'd60000, 17'd60000);     // cool band
        push_reading(17'd67000, 17'd67000);     // rising just past ramp start
        push_reading(17'd70000, 17'd70000);
        push_reading(17'd80000, 17'd80000);
        push_reading(17'd85000, 17'd85000);
        push_reading(17'd86000, 17'd86000);     // exactly hot
        push_reading(17'd85000, 17'd85000);     // falling
        push_reading(17'd75000, 17'd75000);
        push_reading(17'd64000, 17'd64000);
        push_reading(17'd64000, 17'd64000);     // unchanged temperature
        push_reading(17'd63000, 17'd63000);     // exactly cool
        push_reading(17'd66000, 17'd66000);     // rising but not past ramp start
        push_reading(17'd1, 17'd0);             // rounds up to one degree
        push_reading(17'd1000, 17'd1000);       // exactly one degree
        push_reading(17'd1000, 17'd1001);       // just over one degree
        push_reading(17'd127999, 17'd127999);   // top of the nominal range
        push_reading(17'd65999, 17'd1);
        push_reading(17'd0, 17'h1FFFF);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_all_results();

            // Register settings for this phase.
            case (phase)
                0: begin
                    fl = RST_SPEED_FLOOR;  ce = RST_SPEED_CEILING;
                    co = RST_COOL_THRESHOLD; ra = RST_RAMP_THRESHOLD; ho = RST_HOT_THRESHOLD;
                end
                1: begin
                    fl = 16'd0; ce = 16'hFFFF; co = 7'd0; ra = 7'd0; ho = 7'd127;
                end
                2: begin
                    // Ceiling below floor.
                    fl = 16'd50000; ce = 16'd1000; co = 7'd40; ra = 7'd50; ho = 7'd90;
                end
                3: begin
                    // Thresholds out of order.
                    fl = 16'd1500; ce = 16'd9000; co = 7'd100; ra = 7'd90; ho = 7'd50;
                end
                4: begin
                    fl = 16'hFFFF; ce = 16'hFFFF; co = 7'd127; ra = 7'd127; ho = 7'd127;
                end
                8: begin
                    fl = 16'd0; ce = 16'd0; co = 7'd0; ra = 7'd0; ho = 7'd0;
                end
                default: begin
                    fl = 16'($urandom);
                    ce = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(65535, fl))
                                                     : 16'($urandom);
                    if ($urandom_range(0, 4) != 0) begin
                        co = 7'($urandom_range(0, 120));
                        ra = 7'($urandom_range(co, 125));
                        ho = 7'($urandom_range(ra + 1, 127));
                    end
                    else begin
                        co = 7'($urandom);
                        ra = 7'($urandom);
                        ho = 7'($urandom);
                    end
                end
            endcase
            cfg_write(REG_SPEED_FLOOR, fl);
            cfg_write(REG_SPEED_CEILING, ce);
            cfg_write(REG_COOL_THRESHOLD, (phase == 0) ? {9'd0, co} : thr_data(co));
            cfg_write(REG_RAMP_THRESHOLD, (phase == 0) ? {9'd0, ra} : thr_data(ra));
            cfg_write(REG_HOT_THRESHOLD, (phase == 0) ? {9'd0, ho} : thr_data(ho));
            // Writes to unused indexes must leave the settings alone.
            for (k = int'(REG_HOT_THRESHOLD) + 1; k < REG_SPACE; k++)
                cfg_write(3'(k), 16'($urandom));
            cfg_valid <= 1'b0;

            // Idling pattern for this phase.
            case (phase % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 49; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 49; end
                default: begin send_pct = 26; stall_pct = 26; end
            endcase

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    // Noise over the full width of both sensors.
                    a = 17'($urandom);
                    b = 17'($urandom);
                end
                else begin
                    // Temperature walk, mostly in runs of rising or falling.
                    if (roll < 27) begin
                        case ($urandom_range(0, 2))
                            0:       deg = int'(sb.cool_deg);
                            1:       deg = int'(sb.ramp_deg);
                            default: deg = int'(sb.hot_deg);
                        endcase
                        deg = deg + int'($urandom_range(0, 6)) - 3;
                    end
                    else if (roll < 32) begin
                        deg = int'($urandom_range(0, MAX_DEG));
                    end
                    else begin
                        if ($urandom_range(0, 9) == 0)
                            dir = -dir;
                        deg = deg + dir * int'($urandom_range(0, 3));
                    end
                    if (deg < 0)
                        deg = 0;
                    if (deg > MAX_DEG)
                        deg = MAX_DEG;
                    // Split a millidegree sum that rounds up to this degree.
                    if (deg == 0)
                        s = 0;
                    else
                        s = deg * MDEG_PER_DEG - int'($urandom_range(0, MDEG_PER_DEG - 1));
                    if (s > 2 * SENSOR_MAX)
                        s = 2 * SENSOR_MAX;
                    lo = (s > SENSOR_MAX) ? s - SENSOR_MAX : 0;
                    hi = (s < SENSOR_MAX) ? s : SENSOR_MAX;
                    ia = int'($urandom_range(hi, lo));
                    a  = 17'(ia);
                    b  = 17'(s - ia);
                end
                push_reading(a, b);
                if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 99) == 0)
                    wait_all_results();
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.backlog() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tfsc_pkg.sv
sv/temp_to_fan_speed_controller_core.sv
verif/tb_temp_to_fan_speed_controller_core.sv
